FILE: hdl/cftf_pkg.sv
package cftf_pkg;

   // Fixed-point format shared by every stage.
   localparam int FRAC_BITS  = 16;

   // Widths of the intermediate quantities.
   localparam int MD_W       = 63 - FRAC_BITS;   // mass * inv_dt, shifted
   localparam int LIM_W      = 57 - FRAC_BITS;   // mu * |fn|, shifted
   localparam int STK_W      = 64 - FRAC_BITS;   // sticking magnitude
   localparam int MDH_W      = MD_W - 32;        // upper slice of md
   localparam int PH_W       = MDH_W + 32;       // upper partial product
   localparam int FULL_W     = MD_W + 32;        // full md * tn product
   localparam int UA_W       = FRAC_BITS + 1;    // unit direction component
   localparam int PROD_W     = LIM_W + UA_W;     // magnitude * direction
   localparam int ROOT_W     = 32;               // square root result bits
   localparam int DIV_STAGES = UA_W;             // one quotient bit per stage
   localparam int CSR_AW     = 3;

   // Register reset values: mu = 0.5, inv_dt = 1.0.
   localparam logic [24:0] MU_RESET  = 25'((64'(1) << FRAC_BITS) >> 1);
   localparam logic [31:0] ITS_RESET = 32'(64'(1) << FRAC_BITS);

   // Register index codes.
   typedef enum logic {
      REG_MU  = 1'b0,
      REG_ITS = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [24:0] mu;
      logic [31:0] its;
   } cfg_type;

   // Tangential velocity and the two scalars that follow it.
   typedef struct packed {
      logic             valid;
      logic [2:0][31:0] t;
      logic [MD_W-1:0]  md;
      logic [LIM_W-1:0] limit;
   } tang_type;

   // Magnitudes, signs and the norm of the tangential velocity.
   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [2:0]       pos;
      logic [2:0][31:0] ta;
      logic [MD_W-1:0]  md;
      logic [LIM_W-1:0] limit;
      logic [31:0]      tn;
   } root_type;

   // Unit direction, chosen magnitude and the slip flag.
   typedef struct packed {
      logic                  valid;
      logic                  zero;
      logic [2:0]            pos;
      logic [2:0][UA_W-1:0]  ua;
      logic [LIM_W-1:0]      mag;
      logic                  slip;
   } quot_type;

   // Saturate a signed value to the 32-bit signed range.
   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      logic [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/cftf_tangent.sv
module cftf_tangent
   import cftf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [2:0][31:0] vel,
   input  logic [2:0][31:0] norm,
   input  logic [30:0]      mass,
   input  logic [31:0]      fn,
   input  cfg_type          cfg,
   output tang_type         tang
);

   logic               val1_ff, val2_ff, val3_ff, val4_ff;
   logic signed [31:0] v1_ff [3];
   logic signed [31:0] n1_ff [3];
   logic signed [63:0] pv1_ff [3];
   logic [62:0]        mdp1_ff;
   logic [56:0]        limp1_ff;
   logic [31:0]        fn_abs;
   logic signed [63:0] dot_sum;
   logic [31:0]        dot_in;
   logic signed [31:0] dot2_ff;
   logic signed [31:0] v2_ff [3];
   logic signed [31:0] n2_ff [3];
   logic signed [31:0] v3_ff [3];
   logic signed [63:0] pd3_ff [3];
   logic [MD_W-1:0]    md2_ff, md3_ff, md4_ff;
   logic [LIM_W-1:0]   lim2_ff, lim3_ff, lim4_ff;
   logic [2:0][31:0]   t_in;
   logic [2:0][31:0]   t4_ff;

   // Magnitude of the normal force; the most negative value maps to 2^31.
   assign fn_abs = fn[31] ? (~fn + 32'd1) : fn;

   // Dot product of velocity and normal, and the tangential residue.
   always_comb begin
      dot_sum = (pv1_ff[0] >>> FRAC_BITS) + (pv1_ff[1] >>> FRAC_BITS)
              + (pv1_ff[2] >>> FRAC_BITS);
      dot_in  = sat32(dot_sum);
      for (int i = 0; i < 3; i++) begin
         t_in[i] = sat32(64'(v3_ff[i]) - (pd3_ff[i] >>> FRAC_BITS));
      end
   end

   // Valid bits move with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         val1_ff <= 1'b0;
         val2_ff <= 1'b0;
         val3_ff <= 1'b0;
         val4_ff <= 1'b0;
      end else if (adv) begin
         val1_ff <= in_valid;
         val2_ff <= val1_ff;
         val3_ff <= val2_ff;
         val4_ff <= val3_ff;
      end
   end

   // Four stages: products, dot sum, projection, subtraction.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            v1_ff[i]  <= $signed(vel[i]);
            n1_ff[i]  <= $signed(norm[i]);
            pv1_ff[i] <= $signed(vel[i]) * $signed(norm[i]);
            v2_ff[i]  <= v1_ff[i];
            n2_ff[i]  <= n1_ff[i];
            v3_ff[i]  <= v2_ff[i];
            pd3_ff[i] <= dot2_ff * n2_ff[i];
         end
         mdp1_ff  <= 63'(mass) * 63'(cfg.its);
         limp1_ff <= 57'(cfg.mu) * 57'(fn_abs);
         dot2_ff  <= $signed(dot_in);
         md2_ff   <= mdp1_ff[62:FRAC_BITS];
         lim2_ff  <= limp1_ff[56:FRAC_BITS];
         md3_ff   <= md2_ff;
         lim3_ff  <= lim2_ff;
         t4_ff    <= t_in;
         md4_ff   <= md3_ff;
         lim4_ff  <= lim3_ff;
      end
   end

   always_comb begin
      tang.valid = val4_ff;
      tang.t     = t4_ff;
      tang.md    = md4_ff;
      tang.limit = lim4_ff;
   end

endmodule

FILE: hdl/cftf_isqrt.sv
module cftf_isqrt
   import cftf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  tang_type tang,
   output root_type root
);

   logic             val0_ff;
   logic [2:0][31:0] ta_in;
   logic [2:0]       pos_in;
   logic [2:0][31:0] ta0_ff;
   logic [2:0]       pos0_ff;
   logic [63:0]      sq0_ff [3];
   logic [MD_W-1:0]  md0_ff;
   logic [LIM_W-1:0] lim0_ff;
   root_type         r1_ff;
   logic [63:0]      sq1_ff;
   root_type         st_ff [ROOT_W];
   logic [63:0]      rem_ff [ROOT_W];

   // Magnitude and sign of each tangential component.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ta_in[i]  = tang.t[i][31] ? (~tang.t[i] + 32'd1) : tang.t[i];
         pos_in[i] = !tang.t[i][31] && (tang.t[i] != 32'd0);
      end
   end

   // Squares, then their sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         val0_ff     <= 1'b0;
         r1_ff.valid <= 1'b0;
      end else if (adv) begin
         val0_ff     <= tang.valid;
         r1_ff.valid <= val0_ff;
      end
      if (adv) begin
         ta0_ff  <= ta_in;
         pos0_ff <= pos_in;
         for (int i = 0; i < 3; i++) begin
            sq0_ff[i] <= 64'(ta_in[i]) * 64'(ta_in[i]);
         end
         md0_ff      <= tang.md;
         lim0_ff     <= tang.limit;
         sq1_ff      <= sq0_ff[0] + sq0_ff[1] + sq0_ff[2];
         r1_ff.zero  <= (ta0_ff == '0);
         r1_ff.pos   <= pos0_ff;
         r1_ff.ta    <= ta0_ff;
         r1_ff.md    <= md0_ff;
         r1_ff.limit <= lim0_ff;
         r1_ff.tn    <= '0;
      end
   end

   // One root bit per stage, most significant first.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      localparam int B = ROOT_W - 1 - k;
      root_type    prev;
      root_type    st_in;
      logic [63:0] rem_prev;
      logic [63:0] rem_in;
      logic [64:0] trial;

      if (k == 0) begin : g_first
         assign prev     = r1_ff;
         assign rem_prev = sq1_ff;
      end else begin : g_next
         assign prev     = st_ff[k-1];
         assign rem_prev = rem_ff[k-1];
      end

      // Setting this bit costs 2*root*2^B + 2^(2B) of the remainder.
      always_comb begin
         trial  = (65'(prev.tn) << (B + 1)) | (65'(1) << (2 * B));
         st_in  = prev;
         rem_in = rem_prev;
         if (65'(rem_prev) >= trial) begin
            rem_in   = rem_prev - trial[63:0];
            st_in.tn = prev.tn | (32'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k].valid <= 1'b0;
         end else if (adv) begin
            st_ff[k] <= st_in;
         end
         if (adv) begin
            rem_ff[k] <= rem_in;
         end
      end
   end

   assign root = st_ff[ROOT_W-1];

endmodule

FILE: hdl/cftf_div.sv
module cftf_div
   import cftf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  root_type root,
   output quot_type quot
);

   typedef struct packed {
      logic        valid;
      logic        zero;
      logic [2:0]  pos;
      logic [31:0] tn;
   } dside_type;

   dside_type        sd_ff [DIV_STAGES];
   logic [31:0]      rem_ff [DIV_STAGES][3];
   logic [UA_W-1:0]  quo_ff [DIV_STAGES][3];
   logic [PH_W-1:0]  ph_ff;
   logic [63:0]      pl_ff;
   logic [LIM_W-1:0] lima_ff, limb_ff;
   logic [FULL_W-1:0] full;
   logic             ovf;
   logic [STK_W-1:0] stick_in, stick_ff;
   logic             slip_in;
   logic [LIM_W-1:0] mag_in;
   logic [LIM_W-1:0] mag_ff [2:DIV_STAGES-1];
   logic             slip_ff [2:DIV_STAGES-1];

   // Restoring division lanes: |t_i| * 2^F / tn, one quotient bit a stage.
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      dside_type       sd_in;
      logic [31:0]     rem_in [3];
      logic [UA_W-1:0] quo_in [3];
      logic [32:0]     r2 [3];
      logic            q [3];

      if (j == 0) begin : g_first
         // The top bit: |t_i| never exceeds tn, so the quotient is at most one.
         always_comb begin
            sd_in.valid = root.valid;
            sd_in.zero  = root.zero;
            sd_in.pos   = root.pos;
            sd_in.tn    = root.tn;
            for (int i = 0; i < 3; i++) begin
               r2[i]     = 33'(root.ta[i]);
               q[i]      = r2[i] >= {1'b0, root.tn};
               rem_in[i] = q[i] ? 32'(r2[i] - {1'b0, root.tn}) : r2[i][31:0];
               quo_in[i] = UA_W'(q[i]);
            end
         end
      end else begin : g_next
         always_comb begin
            sd_in = sd_ff[j-1];
            for (int i = 0; i < 3; i++) begin
               r2[i]     = {rem_ff[j-1][i], 1'b0};
               q[i]      = r2[i] >= {1'b0, sd_ff[j-1].tn};
               rem_in[i] = q[i] ? 32'(r2[i] - {1'b0, sd_ff[j-1].tn}) : r2[i][31:0];
               quo_in[i] = {quo_ff[j-1][i][UA_W-2:0], q[i]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sd_ff[j].valid <= 1'b0;
         end else if (adv) begin
            sd_ff[j] <= sd_in;
         end
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[j][i] <= rem_in[i];
               quo_ff[j][i] <= quo_in[i];
            end
         end
      end
   end

   // Sticking magnitude, saturated when the product leaves 64 bits, then the slip flag and chosen magnitude.
   always_comb begin
      full     = (FULL_W'(ph_ff) << 32) + FULL_W'(pl_ff);
      ovf      = |full[FULL_W-1:64];
      stick_in = ovf ? '1 : full[63:FRAC_BITS];
      slip_in  = STK_W'(limb_ff) < stick_ff;
      mag_in   = slip_in ? limb_ff : stick_ff[LIM_W-1:0];
   end

   // Magnitude path runs beside the first division stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         ph_ff      <= PH_W'(root.md[MD_W-1:32]) * PH_W'(root.tn);
         pl_ff      <= 64'(root.md[31:0]) * 64'(root.tn);
         lima_ff    <= root.limit;
         stick_ff   <= stick_in;
         limb_ff    <= lima_ff;
         mag_ff[2]  <= mag_in;
         slip_ff[2] <= slip_in;
         for (int k = 3; k < DIV_STAGES; k++) begin
            mag_ff[k]  <= mag_ff[k-1];
            slip_ff[k] <= slip_ff[k-1];
         end
      end
   end

   always_comb begin
      quot.valid = sd_ff[DIV_STAGES-1].valid;
      quot.zero  = sd_ff[DIV_STAGES-1].zero;
      quot.pos   = sd_ff[DIV_STAGES-1].pos;
      for (int i = 0; i < 3; i++) begin
         quot.ua[i] = quo_ff[DIV_STAGES-1][i];
      end
      quot.mag  = mag_ff[DIV_STAGES-1];
      quot.slip = slip_ff[DIV_STAGES-1];
   end

endmodule

FILE: hdl/cftf_scale.sv
module cftf_scale
   import cftf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  quot_type         quot,
   output logic             out_valid,
   output logic [2:0][31:0] force_out,
   output logic             slip_out
);

   logic              valm_ff;
   logic [PROD_W-1:0] fp_ff [3];
   logic [2:0]        posm_ff;
   logic              zerom_ff;
   logic              slipm_ff;
   logic [63:0]       fa [3];
   logic [31:0]       fc [3];
   logic [2:0][31:0]  force_in;
   logic              valo_ff;
   logic [2:0][31:0]  force_ff;
   logic              slip_ff;

   // Scale the direction, cap at 2^31 and apply the opposing sign.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fa[i] = 64'(fp_ff[i][PROD_W-1:FRAC_BITS]);
         fc[i] = (fa[i] > 64'h8000_0000) ? 32'h8000_0000 : fa[i][31:0];
         if (zerom_ff) begin
            force_in[i] = '0;
         end else if (posm_ff[i]) begin
            force_in[i] = ~fc[i] + 32'd1;
         end else if (fc[i] == 32'h8000_0000) begin
            force_in[i] = 32'h7fff_ffff;
         end else begin
            force_in[i] = fc[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valm_ff <= 1'b0;
         valo_ff <= 1'b0;
      end else if (adv) begin
         valm_ff <= quot.valid;
         valo_ff <= valm_ff;
      end
   end

   // Product stage, then the output register.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            fp_ff[i] <= PROD_W'(quot.mag) * PROD_W'(quot.ua[i]);
         end
         posm_ff  <= quot.pos;
         zerom_ff <= quot.zero;
         slipm_ff <= quot.slip;
         force_ff <= force_in;
         slip_ff  <= slipm_ff && !zerom_ff;
      end
   end

   assign out_valid = valo_ff;
   assign force_out = force_ff;
   assign slip_out  = slip_ff;

endmodule

FILE: hdl/coulomb_friction_tangential_force_top.sv
// Channel   Direction  Handshake            Contents
// request   in         req_valid/req_ready  velocity, unit normal, mass, normal force
// response  out        rsp_valid/rsp_ready  friction force x/y/z, slipping flag
// csr       in/out     psel/penable/pready  friction_coeff at 0x0, inv_time_step at 0x4
//
// One request is accepted every cycle unless rsp_ready holds the pipeline; its depth is mostly set
// by the 32-stage square root and the FRAC_BITS+1 stage divider (Q16.16 data).
// Reset clears every valid bit and sets the coefficient to 0.5 and 1/dt to 1.0.
// While a response waits for rsp_ready the whole pipeline holds and req_ready is low.
module coulomb_friction_tangential_force_top
   import cftf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_vel_x,
   input  logic [31:0]       req_vel_y,
   input  logic [31:0]       req_vel_z,
   input  logic [31:0]       req_norm_x,
   input  logic [31:0]       req_norm_y,
   input  logic [31:0]       req_norm_z,
   input  logic [30:0]       req_node_mass,
   input  logic [31:0]       req_normal_force,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_force_x,
   output logic [31:0]       rsp_force_y,
   output logic [31:0]       rsp_force_z,
   output logic              rsp_slipping,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [24:0]      mu_ff;
   logic [31:0]      its_ff;
   cfg_type          cfg;
   logic             adv;
   logic [2:0][31:0] vel;
   logic [2:0][31:0] norm;
   tang_type         tang;
   root_type         root;
   quot_type         quot;
   logic [2:0][31:0] force_out;

   // Register file writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff  <= MU_RESET;
         its_ff <= ITS_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (csr_idx_type'(paddr[CSR_AW-1]))
            REG_MU:  mu_ff  <= pwdata[24:0];
            REG_ITS: its_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // Register file reads.
   always_comb begin
      unique case (csr_idx_type'(paddr[CSR_AW-1]))
         REG_MU:  prdata = 32'(mu_ff);
         REG_ITS: prdata = its_ff;
         default: prdata = '0;
      endcase
   end

   assign pready  = 1'b1;
   assign cfg.mu  = mu_ff;
   assign cfg.its = its_ff;

   // The pipeline moves whenever the output register is free or being emptied.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   assign vel  = {req_vel_z, req_vel_y, req_vel_x};
   assign norm = {req_norm_z, req_norm_y, req_norm_x};

   cftf_tangent u_tangent (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .vel      (vel),
      .norm     (norm),
      .mass     (req_node_mass),
      .fn       (req_normal_force),
      .cfg      (cfg),
      .tang     (tang)
   );

   cftf_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .tang  (tang),
      .root  (root)
   );

   cftf_div u_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .root  (root),
      .quot  (quot)
   );

   cftf_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .quot      (quot),
      .out_valid (rsp_valid),
      .force_out (force_out),
      .slip_out  (rsp_slipping)
   );

   assign rsp_force_x = force_out[0];
   assign rsp_force_y = force_out[1];
   assign rsp_force_z = force_out[2];

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import cftf_pkg::*;

   // Friction force expected for one contact node.
   typedef struct packed {
      logic [31:0] fx;
      logic [31:0] fy;
      logic [31:0] fz;
      logic        slip;
   } force_type;

   localparam int STALL_PCT  = 16;
   localparam int DRAIN_WAIT = 100;
   localparam int DOG_LIMIT  = 3000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [31:0]       req_vel_x = '0;
   logic [31:0]       req_vel_y = '0;
   logic [31:0]       req_vel_z = '0;
   logic [31:0]       req_norm_x = '0;
   logic [31:0]       req_norm_y = '0;
   logic [31:0]       req_norm_z = '0;
   logic [30:0]       req_node_mass = '0;
   logic [31:0]       req_normal_force = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [31:0]       rsp_force_x;
   logic [31:0]       rsp_force_y;
   logic [31:0]       rsp_force_z;
   logic              rsp_slipping;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   // Register copies used by the force predictor.
   logic [24:0] mu_now = MU_RESET;
   logic [31:0] its_now = ITS_RESET;

   force_type   pending_forces[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          calm = 1'b0;

   coulomb_friction_tangential_force_top u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic logic [31:0] clamp32(input longint x);
      if (x > 64'sd2147483647) begin
         return 32'h7fff_ffff;
      end
      if (x < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return x[31:0];
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] val);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'h4000_0000_0000_0000;
      while (b > val) b = b >> 2;
      while (b != 0) begin
         if (val >= res + b) begin
            val = val - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Tangential friction force of one node under the current registers.
   function automatic force_type friction_force(input logic [2:0][31:0] vel,
                                                input logic [2:0][31:0] nrm,
                                                input logic [30:0] mass,
                                                input logic [31:0] fn);
      longint      v[3], n[3], t[3];
      longint      dot, f;
      logic [63:0] sq, tn, md, stick, limit, mag, fn_abs, ta, ua, fa;
      logic [127:0] prod;
      logic [2:0][31:0] frc;
      force_type   r;
      dot = 0;
      sq = '0;
      for (int i = 0; i < 3; i++) begin
         v[i] = longint'($signed(vel[i]));
         n[i] = longint'($signed(nrm[i]));
         dot += (v[i] * n[i]) >>> FRAC_BITS;
      end
      dot = longint'($signed(clamp32(dot)));
      for (int i = 0; i < 3; i++) begin
         t[i] = longint'($signed(clamp32(v[i] - ((dot * n[i]) >>> FRAC_BITS))));
         ta = (t[i] < 0) ? -t[i] : t[i];
         sq += ta * ta;
      end
      r = '0;
      if (sq == 0) begin
         return r;
      end
      tn = root64(sq);
      md = (64'(mass) * 64'(its_now)) >> FRAC_BITS;
      prod = 128'(md) * 128'(tn);
      if (prod[127:64] != 0) begin
         stick = 64'hffff_ffff_ffff_ffff >> FRAC_BITS;
      end else begin
         stick = prod[63:0] >> FRAC_BITS;
      end
      f = longint'($signed(fn));
      fn_abs = (f < 0) ? -f : f;
      limit = (64'(mu_now) * fn_abs) >> FRAC_BITS;
      r.slip = limit < stick;
      mag = r.slip ? limit : stick;
      for (int i = 0; i < 3; i++) begin
         ta = (t[i] < 0) ? -t[i] : t[i];
         ua = (ta << FRAC_BITS) / tn;
         fa = (mag * ua) >> FRAC_BITS;
         if (fa > 64'h8000_0000) fa = 64'h8000_0000;
         f = longint'(fa);
         f = (t[i] > 0) ? -f : f;
         frc[i] = clamp32(f);
      end
      r.fx = frc[0];
      r.fy = frc[1];
      r.fz = frc[2];
      return r;
   endfunction

   // Result side: random back-pressure, then compare against the oldest prediction.
   always @(posedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= STALL_PCT);
   end

   always @(posedge clock) begin
      force_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_forces.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            want = pending_forces.pop_front();
            if (rsp_force_x !== want.fx)
               report($sformatf("force_x %h, wanted %h", rsp_force_x, want.fx));
            if (rsp_force_y !== want.fy)
               report($sformatf("force_y %h, wanted %h", rsp_force_y, want.fy));
            if (rsp_force_z !== want.fz)
               report($sformatf("force_z %h, wanted %h", rsp_force_z, want.fz));
            if (rsp_slipping !== want.slip)
               report($sformatf("slipping %b, wanted %b", rsp_slipping, want.slip));
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= DOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Send one node request and keep the prediction once it is accepted.
   task automatic send_node(input logic [2:0][31:0] vel, input logic [2:0][31:0] nrm,
                            input logic [30:0] mass, input logic [31:0] fn);
      force_type want;
      want = friction_force(vel, nrm, mass, fn);
      req_valid <= 1'b1;
      req_vel_x <= vel[0];
      req_vel_y <= vel[1];
      req_vel_z <= vel[2];
      req_norm_x <= nrm[0];
      req_norm_y <= nrm[1];
      req_norm_z <= nrm[2];
      req_node_mass <= mass;
      req_normal_force <= fn;
      do @(posedge clock); while (!req_ready);
      pending_forces.push_back(want);
      if (!calm && $urandom_range(0, 99) < STALL_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Let the pipeline empty before touching the registers.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_MU) begin
         mu_now = data[24:0];
      end else begin
         its_now = data;
      end
   endtask

   task automatic csr_check(input csr_idx_type idx, input logic [31:0] want);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want)
         report($sformatf("register %0d reads %h, wanted %h", idx, prdata, want));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_friction(input logic [24:0] mu, input logic [31:0] its);
      csr_write(REG_MU, 32'(mu));
      csr_write(REG_ITS, its);
      csr_check(REG_MU, 32'(mu));
      csr_check(REG_ITS, its);
   endtask

   task automatic test_reset_values();
      csr_check(REG_MU, 32'(MU_RESET));
      csr_check(REG_ITS, ITS_RESET);
   endtask

   // Corner nodes: zero and parallel motion, extreme fields, both limits.
   task automatic test_corner_nodes();
      logic [31:0] one, mx, mn;
      one = 32'h0001_0000;
      mx = 32'h7fff_ffff;
      mn = 32'h8000_0000;
      send_node('{0, 0, 0}, '{0, 0, one}, 31'h10000, one);
      send_node('{0, 0, 32'h5_0000}, '{0, 0, one}, 31'h10000, one);
      send_node('{32'hfffd_0000, 0, 0}, '{-one, 0, 0}, 31'h10000, one);
      send_node('{one, 0, 0}, '{0, 0, one}, 31'h10000, 32'h0010_0000);
      send_node('{one, 0, 0}, '{0, 0, one}, 31'h10000, 32'h0000_1000);
      send_node('{0, -one, one}, '{0, 0, one}, 31'h7fff_ffff, mx);
      send_node('{mx, mx, mx}, '{0, 0, one}, 31'h7fff_ffff, mn);
      send_node('{mn, mn, mn}, '{0, one, 0}, 31'h7fff_ffff, mx);
      send_node('{mx, mn, mx}, '{mx, mx, mx}, 31'h7fff_ffff, mn);
      send_node('{mn, mx, mn}, '{mn, mn, mn}, 31'h0, 32'h0);
      send_node('{mx, 0, mn}, '{mn, mx, 0}, 31'h1, 32'h1);
      send_node('{32'h1, 32'hffff_ffff, 0}, '{0, 0, one}, 31'h7fff_ffff, mx);
      send_node('{32'h3_0000, 32'h4_0000, 32'h7_0000}, '{0, 0, one}, 31'h2_0000, mn);
      send_node('{32'h3_0000, 32'h4_0000, 0}, '{32'h0000_b505, 32'h0000_b505, 0},
                31'h8000, 32'hffff_0000);
      send_node('{32'hffff_0000, one, one}, '{one, one, one}, 31'h4_0000, 32'h2_0000);
   endtask

   // Random nodes: mostly unit-axis or small normals, with full-range noise.
   task automatic test_random_nodes(input int count);
      logic [2:0][31:0] vel, nrm;
      logic [30:0] mass;
      logic [31:0] fn;
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 9);
         for (int j = 0; j < 3; j++) begin
            vel[j] = (k < 7) ? 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000)
                             : $urandom;
            nrm[j] = 0;
         end
         if (k < 5) begin
            nrm[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
         end else if (k < 8) begin
            for (int j = 0; j < 3; j++)
               nrm[j] = 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000);
         end else begin
            for (int j = 0; j < 3; j++) nrm[j] = $urandom;
         end
         if ($urandom_range(0, 19) == 0) vel = nrm;
         mass = (k < 7) ? 31'($urandom_range(0, 32'h0010_0000)) : 31'($urandom);
         fn = (k < 7) ? 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000)
                      : $urandom;
         send_node(vel, nrm, mass, fn);
      end
   endtask

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      test_reset_values();
      test_corner_nodes();
      test_random_nodes(250);
      drain();
      set_friction(25'd0, 32'd0);
      test_corner_nodes();
      test_random_nodes(150);
      drain();
      set_friction(25'h100_0000, 32'hffff_ffff);
      test_corner_nodes();
      calm = 1'b1;
      test_random_nodes(200);
      calm = 1'b0;
      test_random_nodes(150);
      drain();
      set_friction(25'h1ff_ffff, 32'h0000_0001);
      test_random_nodes(150);
      drain();
      set_friction(25'($urandom), $urandom);
      test_corner_nodes();
      test_random_nodes(250);
      drain();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
